/* design/scfr_pkg.sv */
// shared types and constants for the serial command frame receiver
// no dependencies; imported by every module of the block
package scfr_pkg;

  localparam int unsigned MAX_PAYLOAD = 248;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_A     = 8'h41;  // 'A'
  localparam logic [7:0] CH_Z     = 8'h5A;  // 'Z'

  localparam logic [15:0] SUM_MOD = 16'hFFFF;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h31;   // '1'
  localparam logic [15:0] BYPASS_CODE_RST    = 16'hAA55;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_BYPASS_CODE    = 1'b1;

  // event codes
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_BYTE = 3'd1;
  localparam logic [2:0] EV_OK   = 3'd2;
  localparam logic [2:0] EV_FMT  = 3'd3;
  localparam logic [2:0] EV_CSUM = 3'd4;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_FUNC = 3'd1,
    PH_ADDR = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  function_code;
    logic [7:0]  payload_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_sum;
  } res_t;

endpackage

/* design/scfr_parse.sv */
// frame parser: per-byte state update and result item
// depends on scfr_pkg
module scfr_parse
  import scfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  device_address,
  input  logic [15:0] bypass_code,
  output res_t        res
);

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [8:0]  frame_bytes, frame_bytes_next;
  logic [7:0]  stored_function, stored_function_next;
  logic [7:0]  stored_length, stored_length_next;
  logic [15:0] data_sum, data_sum_next;
  logic [15:0] rx_checksum, rx_checksum_next;

  logic [8:0]  frame_inc;
  logic [16:0] sum_wide;

  assign frame_inc = frame_bytes + 9'd1;
  assign sum_wide  = {1'b0, data_sum} + {9'd0, rx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      bytes_left      <= '0;
      frame_bytes     <= '0;
      stored_function <= '0;
      stored_length   <= '0;
      data_sum        <= '0;
      rx_checksum     <= '0;
    end else if (take) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      frame_bytes     <= frame_bytes_next;
      stored_function <= stored_function_next;
      stored_length   <= stored_length_next;
      data_sum        <= data_sum_next;
      rx_checksum     <= rx_checksum_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    frame_bytes_next     = frame_bytes;
    stored_function_next = stored_function;
    stored_length_next   = stored_length;
    data_sum_next        = data_sum;
    rx_checksum_next     = rx_checksum;
    res.event_res        = EV_NONE;
    res.payload_byte     = '0;
    res.payload_index    = '0;

    if (phase == PH_HUNT) begin
      if (rx_byte == CH_START) begin
        phase_next           = PH_FUNC;
        frame_bytes_next     = 9'd1;
        stored_function_next = '0;
        stored_length_next   = '0;
        data_sum_next        = '0;
        rx_checksum_next     = '0;
      end
    end else begin
      frame_bytes_next = frame_inc;
      if (frame_inc > 9'(MAX_PAYLOAD)) begin
        // frame too long, whatever the phase
        res.event_res    = EV_FMT;
        phase_next       = PH_HUNT;
        bytes_left_next  = '0;
        frame_bytes_next = '0;
      end else begin
        case (phase)
          PH_FUNC: begin
            if (rx_byte inside {[CH_A:CH_Z]}) begin
              stored_function_next = rx_byte;
              phase_next           = PH_ADDR;
            end else begin
              res.event_res    = EV_FMT;
              phase_next       = PH_HUNT;
              bytes_left_next  = '0;
              frame_bytes_next = '0;
            end
          end
          PH_ADDR: begin
            if (rx_byte == device_address) begin
              phase_next = PH_LEN;
            end else begin
              res.event_res    = EV_FMT;
              phase_next       = PH_HUNT;
              bytes_left_next  = '0;
              frame_bytes_next = '0;
            end
          end
          PH_LEN: begin
            if (rx_byte > 8'(MAX_PAYLOAD)) begin
              res.event_res    = EV_FMT;
              phase_next       = PH_HUNT;
              bytes_left_next  = '0;
              frame_bytes_next = '0;
            end else begin
              stored_length_next = rx_byte;
              if (rx_byte == 8'd0) begin
                phase_next      = PH_CSUM;
                bytes_left_next = 8'd2;
              end else begin
                phase_next      = PH_DATA;
                bytes_left_next = rx_byte;
              end
            end
          end
          PH_DATA: begin
            res.event_res     = EV_BYTE;
            res.payload_byte  = rx_byte;
            res.payload_index = stored_length - bytes_left;
            // running sum modulo 65535, one conditional subtract
            if (sum_wide >= {1'b0, SUM_MOD}) begin
              data_sum_next = 16'(sum_wide - {1'b0, SUM_MOD});
            end else begin
              data_sum_next = sum_wide[15:0];
            end
            if (bytes_left == 8'd1) begin
              phase_next      = PH_CSUM;
              bytes_left_next = 8'd2;
            end else begin
              bytes_left_next = bytes_left - 8'd1;
            end
          end
          PH_CSUM: begin
            if (bytes_left == 8'd2) begin
              rx_checksum_next = {rx_checksum[15:8], rx_byte};
              bytes_left_next  = 8'd1;
            end else begin
              rx_checksum_next = {rx_byte, rx_checksum[7:0]};
              phase_next       = PH_TAIL;
              bytes_left_next  = 8'd2;
            end
          end
          PH_TAIL: begin
            if (bytes_left == 8'd2) begin
              bytes_left_next = 8'd1;
            end else begin
              if (rx_checksum == bypass_code || rx_checksum == data_sum) begin
                res.event_res = EV_OK;
              end else begin
                res.event_res = EV_CSUM;
              end
              phase_next       = PH_HUNT;
              bytes_left_next  = '0;
              frame_bytes_next = '0;
            end
          end
          default: begin
            phase_next       = PH_HUNT;
            bytes_left_next  = '0;
            frame_bytes_next = '0;
          end
        endcase
      end
    end

    res.function_code     = stored_function_next;
    res.payload_length    = stored_length_next;
    res.received_checksum = rx_checksum_next;
    res.computed_sum      = data_sum_next;
  end

  // hunting means no frame is open
  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HUNT |-> frame_bytes == 9'd0 && bytes_left == 8'd0)
    else $error("frame counters not cleared while hunting");

  // an open frame never exceeds the byte limit
  a_frame_bound: assert property (@(posedge clk) disable iff (rst)
    phase != PH_HUNT |-> frame_bytes != 9'd0 && frame_bytes <= 9'(MAX_PAYLOAD))
    else $error("frame byte count out of range");

  // checksum and tail phases count two bytes
  a_csum_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CSUM || phase == PH_TAIL) |-> (bytes_left == 8'd1 || bytes_left == 8'd2))
    else $error("bad byte count in checksum or tail phase");

  // sum stays reduced modulo 65535
  a_sum_reduced: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DATA |=> data_sum != SUM_MOD)
    else $error("payload sum not reduced");

endmodule

/* design/scfr_outq.sv */
// result register with a one-entry skid stage
// depends on scfr_pkg
module scfr_outq
  import scfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res_in,
  output logic full,
  output logic result_valid,
  input  logic result_stall,
  output res_t res_out
);

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;

  assign pop          = main_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = main_valid;
  assign res_out      = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_res <= skid_res;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_res <= res_in;
      end else begin
        main_res <= res_in;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid stage holds an item while result register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("item pushed into a full result queue");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop |=> main_valid && !skid_valid)
    else $error("skid item not moved into result register");

endmodule

/* design/serial_command_frame_receiver.sv */
// serial command frame receiver, top level
// result: each accepted byte's item goes into the result register or, behind it, the skid entry
// throughput: one byte per cycle while byte_stall is low; the frame state update is one short
//   combinational step between the parser registers and the result register
// reset: parser hunts for '$', frame fields zero, address '1', bypass code 0xaa55
// depends on scfr_pkg, scfr_parse, scfr_outq
module serial_command_frame_receiver
  import scfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // received bytes
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  rx_byte,
  // result items
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  event_res,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic [7:0]  function_code,
  output logic [7:0]  payload_length,
  output logic [15:0] received_checksum,
  output logic [15:0] computed_sum
);

  logic [7:0]  device_address;
  logic [15:0] bypass_code;
  logic        take;
  logic        full;
  res_t        res_new;
  res_t        res_held;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RST;
      bypass_code    <= BYPASS_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        CFG_BYPASS_CODE:    bypass_code    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall only when the skid stage is occupied, so one more byte is still taken
  // while a finished result waits in the result register
  assign byte_stall = full;
  assign take       = byte_valid && !byte_stall;

  // frame parser: every accepted byte yields exactly one result item
  scfr_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .rx_byte        (rx_byte),
    .device_address (device_address),
    .bypass_code    (bypass_code),
    .res            (res_new)
  );

  // result register plus skid entry
  scfr_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (take),
    .res_in       (res_new),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_held)
  );

  assign event_res         = res_held.event_res;
  assign payload_byte      = res_held.payload_byte;
  assign payload_index     = res_held.payload_index;
  assign function_code     = res_held.function_code;
  assign payload_length    = res_held.payload_length;
  assign received_checksum = res_held.received_checksum;
  assign computed_sum      = res_held.computed_sum;

endmodule

/* sim/tb.sv */
// testbench for serial_command_frame_receiver: random framed byte traffic, an
// in-bench frame parser that predicts every result item, field-by-field checks
// depends on scfr_pkg and serial_command_frame_receiver from the design folder
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scfr_pkg::*;

  // quiet cycles allowed before the run is called hung; the longest quiet
  // stretch of a correct run is the receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {CS_GOOD, CS_BYPASS, CS_JUNK} csum_kind_t;

  // block inputs, all known from time zero
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_write    = 1'b0;
  logic        cfg_index    = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data     = '0;
  logic        byte_valid   = 1'b0;
  logic [7:0]  rx_byte      = '0;
  logic        result_stall = 1'b0;

  // block outputs
  logic        byte_stall;
  logic        result_valid;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [7:0]  function_code;
  logic [7:0]  payload_length;
  logic [15:0] received_checksum;
  logic [15:0] computed_sum;

  serial_command_frame_receiver i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .rx_byte           (rx_byte),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .event_res         (event_res),
    .payload_byte      (payload_byte),
    .payload_index     (payload_index),
    .function_code     (function_code),
    .payload_length    (payload_length),
    .received_checksum (received_checksum),
    .computed_sum      (computed_sum)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // bytes waiting to go out on the line, and parser events still to arrive
  logic [7:0] line_bytes_q[$];
  res_t       frame_events_q[$];

  int fail_cnt = 0;

  // knobs set by the sequence at the falling edge, read by driver and monitor
  int gap_mode     = 0;  // 0: back-to-back bursts, 1: random gaps between bursts
  int stall_mode   = 0;  // receiver stall pattern
  bit sender_hold  = 1'b0;
  int hold_req     = 0;  // bumped to ask the monitor for one long hold-off

  // ---------------------------------------------------------------------------
  // frame parser: own copy of configuration and parser state
  // ---------------------------------------------------------------------------
  logic [7:0]  my_addr   = DEVICE_ADDRESS_RST;
  logic [15:0] my_bypass = BYPASS_CODE_RST;

  phase_t      rx_phase  = PH_HUNT;
  logic [7:0]  left_cnt  = '0;   // bytes left in the payload or checksum/tail field
  logic [8:0]  frame_cnt = '0;   // bytes of the current frame counting the '$'
  logic [7:0]  cur_func  = '0;
  logic [7:0]  cur_len   = '0;
  logic [15:0] sum_acc   = '0;
  logic [15:0] csum_rx   = '0;

  function automatic void back_to_hunt();
    rx_phase  = PH_HUNT;
    left_cnt  = '0;
    frame_cnt = '0;
  endfunction

  // advances the parser by one received byte and records the event it causes
  function automatic void parse_rx_byte(input logic [7:0] b);
    res_t        r;
    logic [16:0] sum_next;
    r = '0;
    r.event_res = EV_NONE;
    if (rx_phase == PH_HUNT) begin
      // anything but '$' is dropped while hunting
      if (b == CH_START) begin
        rx_phase  = PH_FUNC;
        frame_cnt = 9'd1;
        cur_func  = '0;
        cur_len   = '0;
        sum_acc   = '0;
        csum_rx   = '0;
      end
    end else begin
      frame_cnt = frame_cnt + 9'd1;
      if (frame_cnt > 9'(MAX_PAYLOAD)) begin
        // frame too long, whatever field we are in
        r.event_res = EV_FMT;
        back_to_hunt();
      end else begin
        case (rx_phase)
          PH_FUNC: begin
            if (b < CH_A || b > CH_Z) begin
              r.event_res = EV_FMT;
              back_to_hunt();
            end else begin
              cur_func = b;
              rx_phase = PH_ADDR;
            end
          end
          PH_ADDR: begin
            if (b != my_addr) begin
              r.event_res = EV_FMT;
              back_to_hunt();
            end else begin
              rx_phase = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b > 8'(MAX_PAYLOAD)) begin
              r.event_res = EV_FMT;
              back_to_hunt();
            end else begin
              cur_len = b;
              if (b == 8'd0) begin
                // empty payload skips straight to the checksum
                rx_phase = PH_CSUM;
                left_cnt = 8'd2;
              end else begin
                rx_phase = PH_DATA;
                left_cnt = b;
              end
            end
          end
          PH_DATA: begin
            r.event_res     = EV_BYTE;
            r.payload_byte  = b;
            r.payload_index = cur_len - left_cnt;
            sum_next = {1'b0, sum_acc} + {9'd0, b};
            if (sum_next >= {1'b0, SUM_MOD}) sum_next = sum_next - {1'b0, SUM_MOD};
            sum_acc  = sum_next[15:0];
            left_cnt = left_cnt - 8'd1;
            if (left_cnt == 8'd0) begin
              rx_phase = PH_CSUM;
              left_cnt = 8'd2;
            end
          end
          PH_CSUM: begin
            // little endian: low byte first
            if (left_cnt == 8'd2) begin
              csum_rx[7:0] = b;
              left_cnt     = 8'd1;
            end else begin
              csum_rx[15:8] = b;
              rx_phase      = PH_TAIL;
              left_cnt      = 8'd2;
            end
          end
          PH_TAIL: begin
            if (left_cnt == 8'd2) begin
              left_cnt = 8'd1;
            end else begin
              if (csum_rx == my_bypass || csum_rx == sum_acc) r.event_res = EV_OK;
              else r.event_res = EV_CSUM;
              back_to_hunt();
            end
          end
          default: back_to_hunt();
        endcase
      end
    end
    r.function_code     = cur_func;
    r.payload_length    = cur_len;
    r.received_checksum = csum_rx;
    r.computed_sum      = sum_acc;
    frame_events_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of items, with random gaps between them when gap_mode is set, fed from line_bytes_q
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      // the parser sees the byte at the edge where it is taken
      if (byte_valid && !byte_stall) parse_rx_byte(rx_byte);
      // a stalled item stays on the port untouched
      if (!byte_valid || !byte_stall) begin
        if (gap_left != 0 || sender_hold || line_bytes_q.size() == 0) begin
          byte_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          byte_valid <= 1'b1;
          rx_byte    <= line_bytes_q.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = (gap_mode != 0) ? $urandom_range(1, 8) : 0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result item and drives the receiver stall
  // ---------------------------------------------------------------------------
  int hold_cnt    = 0;
  int hold_served = 0;
  int stall_tick  = 0;

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (frame_events_q.size() == 0) begin
          $error("result item arrived with no item expected");
          fail_cnt++;
        end else begin
          want = frame_events_q.pop_front();
          check_field("event_res", 16'(want.event_res), 16'(event_res));
          check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
          check_field("payload_index", 16'(want.payload_index), 16'(payload_index));
          check_field("function_code", 16'(want.function_code), 16'(function_code));
          check_field("payload_length", 16'(want.payload_length), 16'(payload_length));
          check_field("received_checksum", want.received_checksum, received_checksum);
          check_field("computed_sum", want.computed_sum, computed_sum);
        end
      end
      stall_tick++;
      // long hold-off on request, otherwise the current stall pattern
      if (hold_cnt != 0) begin
        hold_cnt--;
        result_stall <= 1'b1;
      end else if (hold_served != hold_req) begin
        hold_served++;
        hold_cnt = $urandom_range(120, 200);
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= ($urandom_range(0, 3) != 0);
          3:       result_stall <= ((stall_tick % 6) < 2);
          default: result_stall <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_write || (byte_valid && !byte_stall) ||
        (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // register write while the block is idle; the parser copy follows along
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DEVICE_ADDRESS) my_addr = val[7:0];
    else my_bypass = val;
  endtask

  // one full frame with random payload and tail
  function automatic void queue_frame(input logic [7:0] fn, input logic [7:0] addr,
                                      input int len, input csum_kind_t kind);
    logic [7:0]  data;
    int          acc;
    logic [15:0] csum;
    acc = 0;
    line_bytes_q.push_back(CH_START);
    line_bytes_q.push_back(fn);
    line_bytes_q.push_back(addr);
    line_bytes_q.push_back(len[7:0]);
    repeat (len) begin
      data = 8'($urandom_range(0, 255));
      line_bytes_q.push_back(data);
      acc = (acc + data) % 65535;
    end
    case (kind)
      CS_GOOD:   csum = acc[15:0];
      CS_BYPASS: csum = my_bypass;
      default:   csum = 16'($urandom_range(0, 65535));
    endcase
    line_bytes_q.push_back(csum[7:0]);
    line_bytes_q.push_back(csum[15:8]);
    line_bytes_q.push_back(8'($urandom_range(0, 255)));
    line_bytes_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // mostly well-formed frames of small size, the rest broken frames and noise
  function automatic void queue_random_traffic(input int n_bytes);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] fn;
    stop_at = line_bytes_q.size() + n_bytes;
    while (line_bytes_q.size() < stop_at) begin
      pick = $urandom_range(0, 99);
      fn   = 8'($urandom_range(CH_A, CH_Z));
      len  = $urandom_range(0, 99);
      if (len < 6) len = 0;
      else if (len < 90) len = $urandom_range(1, 12);
      else if (len < 98) len = $urandom_range(13, 64);
      else len = $urandom_range(200, MAX_PAYLOAD);
      if (pick < 70) begin
        queue_frame(fn, my_addr, len, csum_kind_t'($urandom_range(0, 2)));
      end else if (pick < 74) begin
        // letter outside 'A'..'Z'
        line_bytes_q.push_back(CH_START);
        line_bytes_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 8'h40)
                                                       : $urandom_range(8'h5B, 8'hFF)));
      end else if (pick < 78) begin
        // someone else's address
        line_bytes_q.push_back(CH_START);
        line_bytes_q.push_back(fn);
        line_bytes_q.push_back(my_addr ^ 8'($urandom_range(1, 255)));
      end else if (pick < 82) begin
        // declared length too large
        line_bytes_q.push_back(CH_START);
        line_bytes_q.push_back(fn);
        line_bytes_q.push_back(my_addr);
        line_bytes_q.push_back(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else if (pick < 88) begin
        // frame cut short, the next bytes land in the middle of it
        queue_frame(fn, my_addr, len, csum_kind_t'($urandom_range(0, 2)));
        repeat ($urandom_range(1, 7)) void'(line_bytes_q.pop_back());
      end else begin
        repeat ($urandom_range(1, 6)) line_bytes_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // waits until every queued item went in and every result came out
  task automatic wait_drained();
    do @(negedge clk);
    while (line_bytes_q.size() != 0 || byte_valid || frame_events_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // sender stops offering until the block has delivered everything
  task automatic pause_sender();
    sender_hold = 1'b1;
    do @(negedge clk);
    while (byte_valid || frame_events_q.size() != 0);
    sender_hold = 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] addr, input logic [15:0] bypass,
                           input int n_bytes, input bit squeeze, input bit with_long);
    int half;
    write_reg(CFG_DEVICE_ADDRESS, {8'h00, addr});
    write_reg(CFG_BYPASS_CODE, bypass);
    @(negedge clk);
    gap_mode   = $urandom_range(0, 1);
    stall_mode = $urandom_range(0, 3);
    if (with_long) begin
      // longest frame that fits, then a payload that runs one byte past the limit
      queue_frame(8'($urandom_range(CH_A, CH_Z)), my_addr, MAX_PAYLOAD - 8, CS_GOOD);
      queue_frame(8'($urandom_range(CH_A, CH_Z)), my_addr, MAX_PAYLOAD - 3, CS_GOOD);
    end
    queue_random_traffic(n_bytes);
    if (squeeze) begin
      // sender keeps pushing while the receiver holds off: block backs up
      gap_mode = 0;
      hold_req++;
    end else begin
      half = line_bytes_q.size() / 2;
      while (line_bytes_q.size() > half) @(negedge clk);
      pause_sender();
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] directed_bytes[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: noise, letter just below 'A' and just above 'Z', wrong address,
    // length one over the limit, empty payload, bypass checksum
    directed_bytes = '{8'h00, 8'hFF,
                       CH_START, CH_A - 8'd1,
                       CH_START, CH_Z + 8'd1,
                       CH_START, CH_A, DEVICE_ADDRESS_RST + 8'd1,
                       CH_START, CH_Z, DEVICE_ADDRESS_RST, 8'(MAX_PAYLOAD + 1)};
    foreach (directed_bytes[i]) line_bytes_q.push_back(directed_bytes[i]);
    queue_frame(CH_A, my_addr, 0, CS_GOOD);
    queue_frame(CH_Z, my_addr, 1, CS_BYPASS);
    wait_drained();

    // register extremes, random settings, then back to the reset values
    run_phase(8'h00, 16'h0000, 20, 1'b0, 1'b0);
    run_phase(8'hFF, 16'hFFFF, 20, 1'b1, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 10, 1'b0, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 20, 1'b1, 1'b0);
    run_phase(DEVICE_ADDRESS_RST, BYPASS_CODE_RST, 20, 1'b0, 1'b0);

    repeat (5) @(negedge clk);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
design/scfr_pkg.sv
design/scfr_parse.sv
design/scfr_outq.sv
design/serial_command_frame_receiver.sv
sim/tb.sv
